// File: rtl/ipl4_pkg.sv
// shared types and constants for the ip layer-4 port header parser
`default_nettype none

package ipl4_pkg;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_HOPOPT = 8'd0;
  localparam logic [7:0] PROTO_ROUTE  = 8'd43;
  localparam logic [7:0] PROTO_FRAG   = 8'd44;
  localparam logic [7:0] PROTO_AH     = 8'd51;
  localparam logic [7:0] PROTO_DSTOPT = 8'd60;

  localparam logic [15:0] V4_BASE_LEN   = 16'd20;
  localparam logic [15:0] V6_BASE_LEN   = 16'd40;
  localparam logic [15:0] TCP_HDR_LEN   = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [15:0] EXT_UNIT_LEN  = 16'd8;
  localparam logic [15:0] V4_PROTO_OFS  = 16'd9;
  localparam logic [15:0] V4_LAST_OFS   = 16'd19;
  localparam logic [15:0] V6_PROTO_OFS  = 16'd6;
  localparam logic [15:0] V6_LAST_OFS   = 16'd39;

  localparam logic [2:0] FLAG_ICMP = 3'b001;
  localparam logic [2:0] FLAG_TCP  = 3'b010;
  localparam logic [2:0] FLAG_UDP  = 3'b100;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_V4,
    PH_V6,
    PH_EXT_OTHER,
    PH_EXT_FRAG,
    PH_EXT_AH,
    PH_L4,
    PH_DONE
  } phase_e;

  // first member sits in the top bits, so is_ipv4 lands in bit 0
  typedef struct packed {
    logic        truncated;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic        is_udp;
    logic        is_tcp;
    logic        is_icmp;
    logic        is_ipv6;
    logic        is_ipv4;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/ipl4_parse.sv
// per-packet parse state and the byte step logic
`default_nettype none

module ipl4_parse #(
  parameter int MAX_EXT_HEADERS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      pkt_byte_i,
  input  wire logic [15:0]     link_type_i,
  input  wire logic            last_i,
  output ipl4_pkg::result_t    res_o
);
  import ipl4_pkg::*;

  logic [15:0] offset_q, offset_d;
  phase_e      phase_q, phase_d;
  logic [15:0] ltype_q, ltype_d;
  logic [15:0] hstart_q, hstart_d;
  logic [15:0] hlen_q, hlen_d;
  logic [7:0]  nproto_q, nproto_d;
  logic [3:0]  ext_cnt_q, ext_cnt_d;
  logic [2:0]  flags_q, flags_d;
  logic [31:0] ports_q, ports_d;

  always_comb begin
    phase_e      ph;
    logic [15:0] rel;
    logic        disp_en;
    logic        disp_v6;
    logic [7:0]  disp_proto;
    logic [15:0] disp_start;
    logic        trunc;
    logic [2:0]  fl;

    ph         = phase_q;
    ltype_d    = ltype_q;
    hstart_d   = hstart_q;
    hlen_d     = hlen_q;
    nproto_d   = nproto_q;
    ext_cnt_d  = ext_cnt_q;
    flags_d    = flags_q;
    ports_d    = ports_q;
    rel        = offset_q - hstart_q;
    disp_en    = 1'b0;
    disp_v6    = 1'b1;
    disp_proto = nproto_q;
    disp_start = V6_BASE_LEN;

    // ethertype is sampled on the first beat of a packet
    if (phase_q == PH_FIRST) begin
      ltype_d = link_type_i;
      if (link_type_i == ETH_IPV4)      ph = PH_V4;
      else if (link_type_i == ETH_IPV6) ph = PH_V6;
      else                              ph = PH_DONE;
    end
    phase_d = ph;

    case (ph)
      PH_V4: begin
        if (offset_q == 16'd0) hstart_d = {10'd0, pkt_byte_i[3:0], 2'b00};
        if (offset_q == V4_PROTO_OFS) nproto_d = pkt_byte_i;
        if (offset_q == V4_LAST_OFS) begin
          disp_en    = 1'b1;
          disp_v6    = 1'b0;
          // short ihl behaves as five words
          disp_start = (hstart_q < V4_BASE_LEN) ? V4_BASE_LEN : hstart_q;
        end
      end
      PH_V6: begin
        if (offset_q == V6_PROTO_OFS) nproto_d = pkt_byte_i;
        if (offset_q == V6_LAST_OFS) disp_en = 1'b1;
      end
      PH_EXT_OTHER, PH_EXT_FRAG, PH_EXT_AH: begin
        if (rel == 16'd0) begin
          nproto_d = pkt_byte_i;
        end else if (rel == 16'd1) begin
          if (ph == PH_EXT_FRAG)     hlen_d = EXT_UNIT_LEN;
          else if (ph == PH_EXT_AH)  hlen_d = {6'd0, pkt_byte_i, 2'b00} + 16'd8;
          else                       hlen_d = {5'd0, pkt_byte_i, 3'b000} + EXT_UNIT_LEN;
        end
        if (rel >= 16'd1 && rel == hlen_d - 16'd1) begin
          disp_en    = 1'b1;
          disp_start = offset_q + 16'd1;
        end
      end
      PH_L4: begin
        if (offset_q >= hstart_q) begin
          if (rel < 16'd4) ports_d = {ports_q[23:0], pkt_byte_i};
          if (rel == hlen_q - 16'd1) phase_d = PH_DONE;
        end
      end
      default: ;
    endcase

    // decide what follows a finished header
    if (disp_en) begin
      if (disp_v6 && ({28'd0, ext_cnt_q} >= 32'(MAX_EXT_HEADERS))) begin
        phase_d = PH_DONE;
      end else if (disp_proto == (disp_v6 ? PROTO_ICMPV6 : PROTO_ICMP)) begin
        flags_d = FLAG_ICMP;
        phase_d = PH_DONE;
      end else if (disp_proto == PROTO_TCP || disp_proto == PROTO_UDP) begin
        flags_d  = (disp_proto == PROTO_TCP) ? FLAG_TCP : FLAG_UDP;
        hlen_d   = (disp_proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
        hstart_d = disp_start;
        phase_d  = PH_L4;
      end else if (disp_v6 && (disp_proto == PROTO_HOPOPT || disp_proto == PROTO_ROUTE ||
                               disp_proto == PROTO_DSTOPT || disp_proto == PROTO_FRAG ||
                               disp_proto == PROTO_AH)) begin
        ext_cnt_d = ext_cnt_q + 4'd1;
        hstart_d  = disp_start;
        hlen_d    = EXT_UNIT_LEN;
        if (disp_proto == PROTO_FRAG)    phase_d = PH_EXT_FRAG;
        else if (disp_proto == PROTO_AH) phase_d = PH_EXT_AH;
        else                             phase_d = PH_EXT_OTHER;
      end else begin
        phase_d = PH_DONE;
      end
    end

    offset_d = (offset_q == 16'hFFFF) ? offset_q : offset_q + 16'd1;

    trunc = (phase_d != PH_DONE) && (phase_d != PH_FIRST);
    fl    = trunc ? 3'b000 : flags_d;
    res_o.is_ipv4     = (ltype_d == ETH_IPV4);
    res_o.is_ipv6     = (ltype_d == ETH_IPV6);
    res_o.is_icmp     = fl[0];
    res_o.is_tcp      = fl[1];
    res_o.is_udp      = fl[2];
    res_o.source_port = (fl[2:1] == 2'b00) ? 16'd0 : ports_d[31:16];
    res_o.dest_port   = (fl[2:1] == 2'b00) ? 16'd0 : ports_d[15:0];
    res_o.truncated   = trunc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      phase_q   <= PH_FIRST;
      ltype_q   <= '0;
      hstart_q  <= '0;
      hlen_q    <= '0;
      nproto_q  <= '0;
      ext_cnt_q <= '0;
      flags_q   <= '0;
      ports_q   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        // packet done, back to the idle values
        offset_q  <= '0;
        phase_q   <= PH_FIRST;
        ltype_q   <= '0;
        hstart_q  <= '0;
        hlen_q    <= '0;
        nproto_q  <= '0;
        ext_cnt_q <= '0;
        flags_q   <= '0;
        ports_q   <= '0;
      end else begin
        offset_q  <= offset_d;
        phase_q   <= phase_d;
        ltype_q   <= ltype_d;
        hstart_q  <= hstart_d;
        hlen_q    <= hlen_d;
        nproto_q  <= nproto_d;
        ext_cnt_q <= ext_cnt_d;
        flags_q   <= flags_d;
        ports_q   <= ports_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ip_l4_port_header_parser.sv
// ip layer-4 port header parser: classifies ipv4/ipv6 packets and extracts ports
// Usage:
//   slave stream: one packet byte per beat in tdata, the ethertype in tuser
//   (sampled on the first beat of a packet), tlast on the final byte.
//   master stream: one result beat per packet, sent after its tlast byte;
//   it carries the ip version, icmp/tcp/udp flags, both ports and a
//   truncated flag (header ran past the end of the packet, drop it).
// Timing:
//   a byte is taken into an input register and stepped through the parse
//   logic from there, and the result of a last byte lands in the output
//   register, which drives the result beat.
//   one byte per cycle sustained while no last byte is held (see Stall).
// Stall:
//   while the output register holds a result the receiver has not taken,
//   non-last bytes keep flowing; a last byte waits in the input register
//   and s_axis_tready_o drops until the result beat is taken.
// Reset:
//   clears the parse state, the input and output valid flags; the first
//   beat after reset starts a new packet.
`default_nettype none

module ip_l4_port_header_parser #(
  parameter int MAX_EXT_HEADERS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] pkt_byte
  input  wire logic [15:0] s_axis_tuser_i,   // [15:0] link_type
  input  wire logic        s_axis_tlast_i,   // end_of_packet
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] is_ipv4, [1] is_ipv6, [2] is_icmp, [3] is_tcp, [4] is_udp,
  // [20:5] source_port, [36:21] dest_port, [37] truncated, [39:38] zero
  output      logic [39:0] m_axis_tdata_o
);
  import ipl4_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [15:0] in_ltype_q;
  logic        in_last_q;
  logic        out_valid_q;
  result_t     out_q;
  result_t     res;
  logic        step;

  // a last byte may only step when the output register is free or being taken
  assign step = in_valid_q && !(in_last_q && out_valid_q && !m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  ipl4_parse #(
    .MAX_EXT_HEADERS(MAX_EXT_HEADERS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pkt_byte_i  (in_byte_q),
    .link_type_i (in_ltype_q),
    .last_i      (in_last_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_ltype_q <= s_axis_tuser_i;
      in_last_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

  // a dropped packet reports no transport and no ports
  a_trunc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.truncated |->
      !out_q.is_icmp && !out_q.is_tcp && !out_q.is_udp &&
      out_q.source_port == 16'd0 && out_q.dest_port == 16'd0)
    else $error("truncated result carries transport info");

  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_q.is_icmp, out_q.is_tcp, out_q.is_udp}))
    else $error("more than one transport flag set");

  a_ports_need_l4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.is_tcp && !out_q.is_udp |->
      out_q.source_port == 16'd0 && out_q.dest_port == 16'd0)
    else $error("ports set without tcp or udp");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && in_last_q))
    else $error("result beat not caused by a last byte");

endmodule

`default_nettype wire
